[rtl/rpn_pkg.sv]
// Package for the RPN stack evaluator: token and status codes, the queue entry type.
// No dependencies; used by the front and back ends and the testbench.
`default_nettype none
package rpn_pkg;

  typedef enum logic [2:0] {
    OP_NUM = 3'd0,
    OP_ADD = 3'd1,
    OP_SUB = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_BAD = 3'd5,
    OP_END = 3'd6,
    OP_UNU = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FEW   = 3'd1,
    ST_DIV0  = 3'd2,
    ST_BADOP = 3'd3,
    ST_LEFT  = 3'd4,
    ST_OVF   = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_READ,
    EX_EXEC,
    EX_PROD,
    EX_MUL,
    EX_DIV,
    EX_WRITE,
    EX_EMIT
  } ex_state_t;

  // One classified token as it travels from the front to the back.
  typedef struct packed {
    op_t         op;
    logic [63:0] value;
  } tok_t;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  // Apply a sign to a magnitude with saturation.
  function automatic logic [63:0] sign_sat(input logic neg, input logic [63:0] mag,
                                           input logic big);
    logic [63:0] r;
    if (!neg) r = (big || mag > POS_MAX) ? POS_MAX : mag;
    else      r = (big || mag > NEG_MIN) ? NEG_MIN : (64'd0 - mag);
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage
`default_nettype wire

[rtl/rpn_stack_evaluator.sv]
// RPN evaluator: one END token gives one result. Tokens go through the front queue
// to the back end, which pushes a number; add/sub read both operands and
// write the result back; multiply adds one partial-product stage, divide runs the
// one-bit-a-cycle restoring divider. END waits for the last result to be taken.
// A two-entry queue lets the front take tokens while the back works.
// Synchronous active-low reset empties the stack, error and queue.
`default_nettype none
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [71:0] in_tdata,   // [2:0] op, [66:3] number_value, rest zero
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata   // [63:0] result_value, [66:64] status, rest zero
);

  logic          q_valid, q_ready;
  rpn_pkg::tok_t q_tok;

  rpn_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_valid(q_valid), .q_ready(q_ready), .q_tok(q_tok)
  );

  rpn_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_tok(q_tok),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule
`default_nettype wire

[rtl/rpn_front.sv]
// Front end of the RPN evaluator: takes tokens and holds them in a short queue.
// Depends on rpn_pkg.
`default_nettype none
module rpn_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [71:0]       in_tdata,
  output logic              q_valid,
  input  wire               q_ready,
  output rpn_pkg::tok_t     q_tok
);

  localparam int QD = 2;

  rpn_pkg::tok_t mem_r [QD];
  logic          wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push, pop;
  rpn_pkg::tok_t in_tok;

  // Classify: the op field and the value from the packed tdata.
  assign in_tok.op    = rpn_pkg::op_t'(in_tdata[2:0]);
  assign in_tok.value = in_tdata[66:3];

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_tok     = mem_r[rp_r];

  // Queue pointers and fill count.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_tok;
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overrun");
  a_cnt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count invalid");
  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 2'd1) else $error("pop count");

endmodule
`default_nettype wire

[rtl/rpn_back.sv]
// Back end of the RPN evaluator: stack memory, ALU, iterative divider, result register.
// Depends on rpn_pkg.
`default_nettype none
module rpn_back #(
  parameter int STACK_DEPTH = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               q_valid,
  output logic              q_ready,
  input  rpn_pkg::tok_t     q_tok,
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [71:0]       out_tdata
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [63:0] stk_r [STACK_DEPTH];

  rpn_pkg::ex_state_t st_r, st_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  rpn_pkg::status_t err_r, err_nxt;
  rpn_pkg::op_t   op_r, op_nxt;
  logic [63:0]    a_r, b_r, rd_r;
  logic [63:0]    res_r, res_nxt;
  logic [63:0]    ov_r, ov_nxt;
  rpn_pkg::status_t os_r, os_nxt;
  logic           ovld_r, ovld_nxt;
  logic [1:0]     rsel_r, rsel_nxt;
  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [63:0]    wdata;
  // Multiplier partial products and divider state.
  logic [63:0]    p00_r, p01_r, p10_r, p11_r;
  logic           neg_r, neg_nxt;
  logic [63:0]    rem_r, rem_nxt, d_r, d_nxt, quo_r, quo_nxt, x_r, x_nxt;
  logic           big_r, big_nxt;
  logic [6:0]     it_r, it_nxt;
  logic [64:0]    trial;
  logic [64:0]    sum65;
  logic [63:0]    mid, lo, hi;
  logic [63:0]    amag;

  assign out_tdata = {5'd0, os_r, ov_r};
  assign out_tvalid = ovld_r;

  // Stack read address, set up for the state being entered: the top entry,
  // the one below it, or the bottom entry for an end token.
  assign raddr = (rsel_nxt == 2'd1) ? AW'(cnt_r - CW'(1)) :
                 (rsel_nxt == 2'd2) ? AW'(cnt_r - CW'(2)) : AW'(0);

  always_ff @(posedge clk) rd_r <= stk_r[raddr];
  always_ff @(posedge clk) begin
    if (we) stk_r[waddr] <= wdata;
  end

  // Magnitude of the lower operand as it arrives from the stack.
  assign amag = rpn_pkg::mag64(rd_r);

  // One restoring division step.
  assign trial = {rem_r, x_r[63]} - {1'b0, d_r};

  // Multiplier low, middle and high words.
  always_comb begin
    mid = {32'd0, p00_r[63:32]} + {32'd0, p01_r[31:0]} + {32'd0, p10_r[31:0]};
    lo  = {mid[31:0], p00_r[31:0]};
    hi  = p11_r + {32'd0, p01_r[63:32]} + {32'd0, p10_r[63:32]} + {32'd0, mid[63:32]};
  end

  // Sequencer: next state, stack writes and results.
  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    err_nxt  = err_r;
    op_nxt   = op_r;
    res_nxt  = res_r;
    ov_nxt   = ov_r;
    os_nxt   = os_r;
    ovld_nxt = ovld_r && !out_tready;
    rsel_nxt = rsel_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    quo_nxt  = quo_r;
    x_nxt    = x_r;
    big_nxt  = big_r;
    it_nxt   = it_r;
    we       = 1'b0;
    waddr    = AW'(cnt_r);
    wdata    = q_tok.value;
    q_ready  = 1'b0;
    sum65    = '0;
    case (st_r)
      rpn_pkg::EX_IDLE: begin
        if (q_valid) begin
          op_nxt = q_tok.op;
          if (q_tok.op == rpn_pkg::OP_END) begin
            if (!ovld_nxt) begin
              q_ready  = 1'b1;
              rsel_nxt = 2'd0;
              st_nxt   = rpn_pkg::EX_EMIT;
            end
          end else begin
            q_ready = 1'b1;
            if (err_r != rpn_pkg::ST_OK) begin
              st_nxt = rpn_pkg::EX_IDLE;
            end else if (q_tok.op == rpn_pkg::OP_NUM) begin
              if (cnt_r >= CW'(STACK_DEPTH)) err_nxt = rpn_pkg::ST_OVF;
              else begin
                we      = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end else if (cnt_r < CW'(2)) begin
              err_nxt = rpn_pkg::ST_FEW;
            end else begin
              rsel_nxt = 2'd1;
              st_nxt   = rpn_pkg::EX_READ;
            end
          end
        end
      end
      rpn_pkg::EX_READ: begin
        // b is read now; a next cycle.
        rsel_nxt = 2'd2;
        st_nxt   = rpn_pkg::EX_EXEC;
      end
      rpn_pkg::EX_EXEC: begin
        cnt_nxt = cnt_r - CW'(2);
        neg_nxt = rd_r[63] ^ b_r[63];
        case (op_r)
          rpn_pkg::OP_ADD: begin
            res_nxt = rd_r + b_r;
            if (rd_r[63] == b_r[63] && res_nxt[63] != rd_r[63])
              res_nxt = rd_r[63] ? rpn_pkg::NEG_MIN : rpn_pkg::POS_MAX;
            st_nxt = rpn_pkg::EX_WRITE;
          end
          rpn_pkg::OP_SUB: begin
            res_nxt = rd_r - b_r;
            if (rd_r[63] != b_r[63] && res_nxt[63] != rd_r[63])
              res_nxt = rd_r[63] ? rpn_pkg::NEG_MIN : rpn_pkg::POS_MAX;
            st_nxt = rpn_pkg::EX_WRITE;
          end
          rpn_pkg::OP_MUL: st_nxt = rpn_pkg::EX_PROD;
          rpn_pkg::OP_DIV: begin
            if (b_r == 64'd0) begin
              err_nxt = rpn_pkg::ST_DIV0;
              st_nxt  = rpn_pkg::EX_IDLE;
            end else begin
              d_nxt   = rpn_pkg::mag64(b_r);
              rem_nxt = {32'd0, amag[63:32]};
              x_nxt   = {amag[31:0], 32'd0};
              quo_nxt = '0;
              big_nxt = (rem_nxt >= d_nxt);
              it_nxt  = 7'd0;
              st_nxt  = rpn_pkg::EX_DIV;
            end
          end
          default: begin
            err_nxt = rpn_pkg::ST_BADOP;
            st_nxt  = rpn_pkg::EX_IDLE;
          end
        endcase
      end
      rpn_pkg::EX_PROD: begin
        // The partial products of the two magnitudes are registered now.
        st_nxt = rpn_pkg::EX_MUL;
      end
      rpn_pkg::EX_MUL: begin
        res_nxt = rpn_pkg::sign_sat(neg_r, {hi[31:0], lo[63:32]}, hi[63:32] != 32'd0);
        st_nxt  = rpn_pkg::EX_WRITE;
      end
      rpn_pkg::EX_DIV: begin
        // The high 32 quotient bits only flag overflow, so the walk starts
        // with the high word as remainder; big is set if it already covers d.
        sum65   = trial;
        rem_nxt = sum65[64] ? {rem_r[62:0], x_r[63]} : sum65[63:0];
        quo_nxt = {quo_r[62:0], ~sum65[64]};
        x_nxt   = {x_r[62:0], 1'b0};
        if (rem_r[63] && !sum65[64]) begin
          rem_nxt = sum65[63:0];
        end
        it_nxt = it_r + 7'd1;
        if (it_r == 7'd63) begin
          res_nxt = rpn_pkg::sign_sat(neg_r, quo_nxt, big_r);
          st_nxt  = rpn_pkg::EX_WRITE;
        end
      end
      rpn_pkg::EX_WRITE: begin
        we      = 1'b1;
        wdata   = res_r;
        cnt_nxt = cnt_r + CW'(1);
        st_nxt  = rpn_pkg::EX_IDLE;
      end
      rpn_pkg::EX_EMIT: begin
        ovld_nxt = 1'b1;
        if (err_r != rpn_pkg::ST_OK) begin
          ov_nxt = '0;
          os_nxt = err_r;
        end else if (cnt_r != CW'(1)) begin
          ov_nxt = '0;
          os_nxt = rpn_pkg::ST_LEFT;
        end else begin
          ov_nxt = rd_r;
          os_nxt = rpn_pkg::ST_OK;
        end
        cnt_nxt = '0;
        err_nxt = rpn_pkg::ST_OK;
        st_nxt  = rpn_pkg::EX_IDLE;
      end
      default: st_nxt = rpn_pkg::EX_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= rpn_pkg::EX_IDLE;
      cnt_r  <= '0;
      err_r  <= rpn_pkg::ST_OK;
      ovld_r <= 1'b0;
      rsel_r <= 2'd0;
      it_r   <= 7'd0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      err_r  <= err_nxt;
      ovld_r <= ovld_nxt;
      rsel_r <= rsel_nxt;
      it_r   <= it_nxt;
    end
  end

  // Datapath registers; b latches the top entry as it arrives.
  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    res_r <= res_nxt;
    ov_r  <= ov_nxt;
    os_r  <= os_nxt;
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    quo_r <= quo_nxt;
    x_r   <= x_nxt;
    big_r <= big_nxt;
    a_r   <= (st_r == rpn_pkg::EX_EXEC) ? amag : a_r;
    if (st_r == rpn_pkg::EX_READ) b_r <= rd_r;
    else if (st_r == rpn_pkg::EX_EXEC) b_r <= rpn_pkg::mag64(b_r);
    p00_r <= {32'd0, a_r[31:0]}  * {32'd0, b_r[31:0]};
    p01_r <= {32'd0, a_r[31:0]}  * {32'd0, b_r[63:32]};
    p10_r <= {32'd0, a_r[63:32]} * {32'd0, b_r[31:0]};
    p11_r <= {32'd0, a_r[63:32]} * {32'd0, b_r[63:32]};
  end

  a_cnt_rng: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(STACK_DEPTH)) else $error("stack count out of range");
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == rpn_pkg::EX_EMIT |=> out_tvalid && err_r == rpn_pkg::ST_OK)
    else $error("end did not emit");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");

endmodule
`default_nettype wire

[tb/sv/tb_rpn_stack_evaluator.sv]
// Testbench for the RPN stack evaluator: directed token table, then random expressions.
// Results are checked against a built-in expression predictor. Depends on rpn_pkg.
`default_nettype none
module tb_rpn_stack_evaluator;

  localparam int DEPTH = 16;
  localparam int TOKENS = 1650;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    rpn_pkg::op_t     op;
    logic [63:0]      val;
    logic             known;
    logic [63:0]      want_val;
    rpn_pkg::status_t want_st;
  } row_t;

  typedef struct {
    logic [63:0]      val;
    rpn_pkg::status_t st;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  // Predictor state.
  logic [63:0]      pred_stack [DEPTH];
  int               pred_count = 0;
  rpn_pkg::status_t pred_err = rpn_pkg::ST_OK;

  answer_t answers [$];
  int      mismatches = 0;
  int      send_idle = 27;
  int      recv_idle = 62;
  int      sent_tokens = 0;
  bit      hold_recv = 1'b0;
  longint  cycles = 0;

  rpn_stack_evaluator #(.STACK_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] absval(logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] signed_sat(logic neg, logic [63:0] m, logic big);
    if (!neg) return (big || m > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m;
    return (big || m > 64'h8000_0000_0000_0000) ? 64'h8000_0000_0000_0000 : (64'd0 - m);
  endfunction

  function automatic logic [63:0] fx_add(logic [63:0] a, logic [63:0] b, logic minus);
    logic [64:0] s;
    logic signed [64:0] r;
    if (minus) r = $signed({a[63], a}) - $signed({b[63], b});
    else       r = $signed({a[63], a}) + $signed({b[63], b});
    s = r;
    if (s[64] != s[63]) return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    return s[63:0];
  endfunction

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = absval(a) * absval(b);
    return signed_sat(a[63] ^ b[63], p[95:32], |p[127:96]);
  endfunction

  function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
    logic [127:0] q;
    q = {32'd0, absval(a), 32'd0} / {64'd0, absval(b)};
    return signed_sat(a[63] ^ b[63], q[63:0], |q[127:64]);
  endfunction

  // Advance the evaluator model by one token; queue an answer on end.
  task automatic eval_token(rpn_pkg::op_t op, logic [63:0] v);
    logic [63:0] a, b;
    if (op == rpn_pkg::OP_END) begin
      if (pred_err != rpn_pkg::ST_OK) answers.push_back('{64'd0, pred_err});
      else if (pred_count != 1) answers.push_back('{64'd0, rpn_pkg::ST_LEFT});
      else answers.push_back('{pred_stack[0], rpn_pkg::ST_OK});
      pred_count = 0;
      pred_err = rpn_pkg::ST_OK;
    end else if (pred_err != rpn_pkg::ST_OK) begin
    end else if (op == rpn_pkg::OP_NUM) begin
      if (pred_count >= DEPTH) pred_err = rpn_pkg::ST_OVF;
      else begin
        pred_stack[pred_count] = v;
        pred_count++;
      end
    end else if (pred_count < 2) begin
      pred_err = rpn_pkg::ST_FEW;
    end else begin
      b = pred_stack[pred_count-1];
      a = pred_stack[pred_count-2];
      pred_count -= 2;
      case (op)
        rpn_pkg::OP_ADD: pred_stack[pred_count++] = fx_add(a, b, 1'b0);
        rpn_pkg::OP_SUB: pred_stack[pred_count++] = fx_add(a, b, 1'b1);
        rpn_pkg::OP_MUL: pred_stack[pred_count++] = fx_mul(a, b);
        rpn_pkg::OP_DIV: begin
          if (b == 64'd0) pred_err = rpn_pkg::ST_DIV0;
          else pred_stack[pred_count++] = fx_div(a, b);
        end
        default: pred_err = rpn_pkg::ST_BADOP;
      endcase
    end
  endtask

  // Offer one token and hold it until the transfer; valid drops only while idling.
  task automatic send_token(rpn_pkg::op_t op, logic [63:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'd0, v, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    eval_token(op, v);
    sent_tokens++;
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return {$urandom_range(8), 32'd0};
      2: return 64'd0 - {28'd0, 4'($urandom_range(15)), $urandom};
      3: return {$urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000, $urandom};
      default: return {{16{$urandom_range(1) ? 1'b1 : 1'b0}}, 16'($urandom), $urandom};
    endcase
  endfunction

  // A well-formed expression of random depth, optionally spoiled.
  task automatic send_expression();
    int held;
    int n;
    held = 0;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if (held < 2 || (held < DEPTH && $urandom_range(1))) begin
        send_token(rpn_pkg::OP_NUM, rand_value());
        held++;
      end else begin
        send_token(rpn_pkg::op_t'($urandom_range(rpn_pkg::OP_ADD, rpn_pkg::OP_DIV)), 64'd0);
        held--;
      end
    end
    while (held > 1) begin
      send_token(rpn_pkg::op_t'($urandom_range(rpn_pkg::OP_ADD, rpn_pkg::OP_DIV)),
                 rand_value());
      held--;
    end
    if ($urandom_range(9) == 0) send_token(rpn_pkg::op_t'($urandom_range(7)), rand_value());
    send_token(rpn_pkg::OP_END, rand_value());
  endtask

  task automatic run_table();
    row_t rows [$];
    rows = '{
      '{rpn_pkg::OP_END, 64'd0, 1'b1, 64'd0, rpn_pkg::ST_LEFT},
      '{rpn_pkg::OP_NUM, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_END, 64'd0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_NUM, 64'h8000_0000_0000_0000, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_NUM, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_ADD, 64'd0, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_NUM, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_SUB, 64'd0, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_END, 64'd0, 1'b1, 64'h8000_0000_0000_0000, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_NUM, 64'h0000_0003_8000_0000, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_NUM, 64'hFFFF_FFFE_0000_0000, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_MUL, 64'd0, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_NUM, 64'h0000_0000_0000_0003, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_DIV, 64'd0, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_END, 64'd0, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_NUM, 64'd5, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_NUM, 64'd0, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_DIV, 64'd0, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_END, 64'd0, 1'b1, 64'd0, rpn_pkg::ST_DIV0},
      '{rpn_pkg::OP_ADD, 64'd0, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_END, 64'd0, 1'b1, 64'd0, rpn_pkg::ST_FEW},
      '{rpn_pkg::OP_NUM, 64'd1, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_NUM, 64'd2, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_BAD, 64'd0, 1'b0, 64'd0, rpn_pkg::ST_OK},
      '{rpn_pkg::OP_END, 64'd0, 1'b1, 64'd0, rpn_pkg::ST_BADOP}
    };
    foreach (rows[i]) begin
      send_token(rows[i].op, rows[i].val);
      // Known rows pin the predictor to hand-read answers.
      if (rows[i].known && (answers[$].val !== rows[i].want_val ||
                            answers[$].st !== rows[i].want_st)) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row %0d: expected value %h status %0d, predicted %h status %0d",
                   i, rows[i].want_val, rows[i].want_st, answers[$].val, answers[$].st);
      end
    end
    // The unused operator code, a stack overflow, then a full stack summed by adds.
    send_token(rpn_pkg::OP_NUM, 64'd1);
    send_token(rpn_pkg::OP_NUM, 64'd2);
    send_token(rpn_pkg::OP_UNU, 64'd0);
    send_token(rpn_pkg::OP_END, 64'd0);
    for (int i = 0; i <= DEPTH; i++) send_token(rpn_pkg::OP_NUM, {$urandom, $urandom});
    send_token(rpn_pkg::OP_END, 64'd0);
    for (int i = 0; i < DEPTH; i++) send_token(rpn_pkg::OP_NUM, 64'(i));
    for (int i = 1; i < DEPTH; i++) send_token(rpn_pkg::OP_ADD, 64'd0);
    send_token(rpn_pkg::OP_END, 64'd0);
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_recv) begin
        out_tready <= 1'b0;
        hold = 0;
        while (hold < 400) begin
          @(posedge clk);
          hold++;
        end
        hold_recv = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Compare each result transfer with the oldest expected answer.
  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst_n && out_tvalid && out_tready) begin
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_ans = answers.pop_front();
        if (out_tdata[63:0] !== exp_ans.val || out_tdata[66:64] !== exp_ans.st ||
            out_tdata[71:67] !== 5'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h status %0d, got value %h status %0d",
                     exp_ans.val, exp_ans.st, out_tdata[63:0], out_tdata[66:64]);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int settle;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_table();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 27 : (phase == 1) ? 62 : 0;
      recv_idle = (phase == 0) ? 62 : (phase == 1) ? 27 : 0;
      if (phase == 1) hold_recv = 1'b1;
      while (sent_tokens < (phase + 1) * TOKENS / 3) begin
        if ($urandom_range(19) == 0) begin
          send_token(rpn_pkg::op_t'($urandom_range(7)), rand_value());
        end else begin
          send_expression();
        end
      end
    end
    in_tvalid <= 1'b0;
    while (answers.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk);
      settle++;
    end
    if (mismatches == 0 && answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
